// ===== rtl/assert_macros.svh =====
// Assertion macros used by the calculator ALU top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define CICA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define CICA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cica_pkg.sv =====
// Package with the codes, limits and sequencer states of the calculator ALU.
package cica_pkg;

  localparam int OPERAND_DIGITS = 9;
  localparam int RESULT_WIDTH   = 32;
  localparam int DIGIT_MAX      = 10 ** OPERAND_DIGITS - 1;

  localparam logic signed [30:0] LOAD_MAX = 31'(DIGIT_MAX);
  localparam logic signed [30:0] LOAD_MIN = -31'(DIGIT_MAX);
  localparam logic [31:0] RESULT_LIMIT = 32'((64'd1 << (RESULT_WIDTH - 1)) - 64'd1);

  localparam logic [3:0] OP_LOAD_A = 4'd0;
  localparam logic [3:0] OP_LOAD_B = 4'd1;
  localparam logic [3:0] OP_SWAP   = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_SUB    = 4'd4;
  localparam logic [3:0] OP_MUL    = 4'd5;
  localparam logic [3:0] OP_DIV    = 4'd6;
  localparam logic [3:0] OP_POW    = 4'd7;
  localparam logic [3:0] OP_ROOT   = 4'd8;

  localparam logic [2:0] STS_NONE    = 3'd0;
  localparam logic [2:0] STS_OK      = 3'd1;
  localparam logic [2:0] STS_DIVZ    = 3'd2;
  localparam logic [2:0] STS_EVNEG   = 3'd3;
  localparam logic [2:0] STS_ZDEG    = 3'd4;
  localparam logic [2:0] STS_MUL_OVF = 3'd5;
  localparam logic [2:0] STS_POW_OVF = 3'd6;
  localparam logic [2:0] STS_ZNEG    = 3'd7;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_MUL_W    = 10'b0000000010,
    S_MUL_CHK  = 10'b0000000100,
    S_DIV      = 10'b0000001000,
    S_RT_NEXT  = 10'b0000010000,
    S_PW_START = 10'b0000100000,
    S_PW_MUL   = 10'b0001000000,
    S_PW_CHK   = 10'b0010000000,
    S_PW_RET   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

endpackage

// ===== rtl/cica_mul_unit.sv =====
// Shared registered 32 by 32 unsigned multiplier of the calculator ALU.
module cica_mul_unit (
  input  logic        clk,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic [63:0] prod_r
);

  logic [63:0] prod_nxt;

  assign prod_nxt = {32'd0, x_i} * {32'd0, y_i};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/checked_integer_calculator_alu_top.sv =====
// Top level of the checked integer calculator ALU: sequencer, operands and output register.
//
// Channel | Direction | Fields (low bit first)
// in_*    | input     | tdata: operation[3:0], load_value[34:4], zero fill [39:35]
// out_*   | output    | tdata: result_value[31:0], status_code[34:32], zero fill [39:35]
//
// Load, swap, add, subtract and special cases go to S_DONE; multiply runs S_MUL_W, S_MUL_CHK.
// Divide runs one restoring step per quotient bit in S_DIV.
// Power runs the shared multiplier once per factor, through S_PW_MUL and S_PW_CHK.
// Root tests 16 result bits, each a capped power on the shared multiplier.
// Reset clears both operands and the control state; in_tready is high only when idle.
// A result waiting on out_tready holds the block in its final state.
module checked_integer_calculator_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[3:0], load_value[34:4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_value[31:0], status_code[34:32]
);

  `include "assert_macros.svh"

  cica_pkg::state_t state_r, state_nxt;
  logic signed [30:0] a_r, a_nxt, b_r, b_nxt;
  logic [31:0] res_r, res_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_res_r, out_res_nxt;
  logic [2:0]  out_st_r, out_st_nxt;
  logic        neg_r, neg_nxt;
  logic        root_mode_r, root_mode_nxt;
  logic [31:0] acc_r, acc_nxt, base_r, base_nxt, cap_r, cap_nxt, val_r, val_nxt;
  logic [30:0] cnt_r, cnt_nxt;
  logic        over_r, over_nxt;
  logic [15:0] root_r, root_nxt;
  logic [3:0]  rbit_r, rbit_nxt;
  logic [30:0] quo_r, quo_nxt, rem_r, rem_nxt;

  logic        in_fire;
  logic [3:0]  in_op;
  logic signed [30:0] lv_raw, lv_sat;
  logic [30:0] ma, mb;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_prod;
  logic [30:0] div_sh;
  logic        div_ge;
  logic [30:0] div_q;
  logic [15:0] root_fin;

  assign in_tready  = (state_r == cica_pkg::S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_op      = in_tdata[3:0];
  assign lv_raw     = in_tdata[34:4];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_st_r, out_res_r};

  assign ma = a_r[30] ? 31'(-a_r) : a_r;
  assign mb = b_r[30] ? 31'(-b_r) : b_r;

  assign mul_x = (state_r == cica_pkg::S_MUL_W) ? {1'b0, ma} : acc_r;
  assign mul_y = (state_r == cica_pkg::S_MUL_W) ? {1'b0, mb} : base_r;

  cica_mul_unit u_mul (
    .clk    (clk),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .prod_r (mul_prod)
  );

  assign div_sh   = {rem_r[29:0], quo_r[30]};
  assign div_ge   = (div_sh >= mb);
  assign div_q    = {quo_r[29:0], div_ge};
  assign root_fin = over_r ? root_r : base_r[15:0];

  always_comb begin
    if (lv_raw > cica_pkg::LOAD_MAX) begin
      lv_sat = cica_pkg::LOAD_MAX;
    end else if (lv_raw < cica_pkg::LOAD_MIN) begin
      lv_sat = cica_pkg::LOAD_MIN;
    end else begin
      lv_sat = lv_raw;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;
    neg_nxt       = neg_r;
    root_mode_nxt = root_mode_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    cap_nxt       = cap_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    over_nxt      = over_r;
    root_nxt      = root_r;
    rbit_nxt      = rbit_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      cica_pkg::S_IDLE: begin
        if (in_fire) begin
          res_nxt   = 32'd0;
          st_nxt    = cica_pkg::STS_NONE;
          state_nxt = cica_pkg::S_DONE;
          case (in_op)
            cica_pkg::OP_LOAD_A: a_nxt = lv_sat;
            cica_pkg::OP_LOAD_B: b_nxt = lv_sat;
            cica_pkg::OP_SWAP: begin
              a_nxt = b_r;
              b_nxt = a_r;
            end
            cica_pkg::OP_ADD: begin
              res_nxt = {a_r[30], a_r} + {b_r[30], b_r};
              st_nxt  = cica_pkg::STS_OK;
            end
            cica_pkg::OP_SUB: begin
              res_nxt = {a_r[30], a_r} - {b_r[30], b_r};
              st_nxt  = cica_pkg::STS_OK;
            end
            cica_pkg::OP_MUL: begin
              if (a_r == '0 || b_r == '0) begin
                st_nxt = cica_pkg::STS_OK;
              end else begin
                neg_nxt   = a_r[30] ^ b_r[30];
                state_nxt = cica_pkg::S_MUL_W;
              end
            end
            cica_pkg::OP_DIV: begin
              if (b_r == '0) begin
                st_nxt = cica_pkg::STS_DIVZ;
              end else begin
                neg_nxt   = a_r[30] ^ b_r[30];
                quo_nxt   = ma;
                rem_nxt   = '0;
                cnt_nxt   = 31'd31;
                state_nxt = cica_pkg::S_DIV;
              end
            end
            cica_pkg::OP_POW: begin
              if (a_r == '0 && b_r[30]) begin
                st_nxt = cica_pkg::STS_ZNEG;
              end else if (b_r[30]) begin
                st_nxt = cica_pkg::STS_OK;
                if (a_r == 31'sd1) begin
                  res_nxt = 32'd1;
                end else if (a_r == -31'sd1) begin
                  res_nxt = b_r[0] ? 32'hFFFF_FFFF : 32'd1;
                end
              end else begin
                neg_nxt       = a_r[30] & b_r[0];
                root_mode_nxt = 1'b0;
                base_nxt      = {1'b0, ma};
                cap_nxt       = cica_pkg::RESULT_LIMIT;
                cnt_nxt       = b_r;
                state_nxt     = cica_pkg::S_PW_START;
              end
            end
            cica_pkg::OP_ROOT: begin
              if (!b_r[0] && a_r[30]) begin
                st_nxt = cica_pkg::STS_EVNEG;
              end else if (b_r == '0) begin
                st_nxt = cica_pkg::STS_ZDEG;
              end else if (b_r[30]) begin
                if (a_r == '0) begin
                  st_nxt = cica_pkg::STS_DIVZ;
                end else begin
                  st_nxt = cica_pkg::STS_OK;
                  if (ma == 31'd1) begin
                    res_nxt = {a_r[30], a_r};
                  end
                end
              end else if (b_r == 31'sd1) begin
                st_nxt  = cica_pkg::STS_OK;
                res_nxt = {a_r[30], a_r};
              end else begin
                neg_nxt       = a_r[30];
                root_mode_nxt = 1'b1;
                cap_nxt       = {1'b0, ma};
                root_nxt      = '0;
                rbit_nxt      = 4'd15;
                state_nxt     = cica_pkg::S_RT_NEXT;
              end
            end
            default: ;
          endcase
        end
      end
      cica_pkg::S_MUL_W: begin
        state_nxt = cica_pkg::S_MUL_CHK;
      end
      cica_pkg::S_MUL_CHK: begin
        if (mul_prod + {33'd0, mb} <= {32'd0, cica_pkg::RESULT_LIMIT}) begin
          res_nxt = neg_r ? -mul_prod[31:0] : mul_prod[31:0];
          st_nxt  = cica_pkg::STS_OK;
        end else begin
          st_nxt = cica_pkg::STS_MUL_OVF;
        end
        state_nxt = cica_pkg::S_DONE;
      end
      cica_pkg::S_DIV: begin
        rem_nxt = div_ge ? (div_sh - mb) : div_sh;
        quo_nxt = div_q;
        cnt_nxt = cnt_r - 31'd1;
        if (cnt_r == 31'd1) begin
          res_nxt   = neg_r ? -{1'b0, div_q} : {1'b0, div_q};
          st_nxt    = cica_pkg::STS_OK;
          state_nxt = cica_pkg::S_DONE;
        end
      end
      cica_pkg::S_RT_NEXT: begin
        base_nxt  = {16'd0, root_r | (16'd1 << rbit_r)};
        cnt_nxt   = b_r;
        state_nxt = cica_pkg::S_PW_START;
      end
      cica_pkg::S_PW_START: begin
        if (cnt_r == '0) begin
          val_nxt   = 32'd1;
          over_nxt  = (cap_r == 32'd0);
          state_nxt = cica_pkg::S_PW_RET;
        end else if (base_r <= 32'd1) begin
          val_nxt   = base_r;
          over_nxt  = (base_r > cap_r);
          state_nxt = cica_pkg::S_PW_RET;
        end else begin
          acc_nxt   = 32'd1;
          state_nxt = cica_pkg::S_PW_MUL;
        end
      end
      cica_pkg::S_PW_MUL: begin
        state_nxt = cica_pkg::S_PW_CHK;
      end
      cica_pkg::S_PW_CHK: begin
        if (mul_prod > {32'd0, cap_r}) begin
          over_nxt  = 1'b1;
          state_nxt = cica_pkg::S_PW_RET;
        end else begin
          acc_nxt = mul_prod[31:0];
          cnt_nxt = cnt_r - 31'd1;
          if (cnt_r == 31'd1) begin
            over_nxt  = 1'b0;
            val_nxt   = mul_prod[31:0];
            state_nxt = cica_pkg::S_PW_RET;
          end else begin
            state_nxt = cica_pkg::S_PW_MUL;
          end
        end
      end
      cica_pkg::S_PW_RET: begin
        if (!root_mode_r) begin
          if (over_r) begin
            st_nxt = cica_pkg::STS_POW_OVF;
          end else begin
            res_nxt = neg_r ? -val_r : val_r;
            st_nxt  = cica_pkg::STS_OK;
          end
          state_nxt = cica_pkg::S_DONE;
        end else begin
          root_nxt = root_fin;
          if (rbit_r == 4'd0) begin
            res_nxt   = neg_r ? -{16'd0, root_fin} : {16'd0, root_fin};
            st_nxt    = cica_pkg::STS_OK;
            state_nxt = cica_pkg::S_DONE;
          end else begin
            rbit_nxt  = rbit_r - 4'd1;
            state_nxt = cica_pkg::S_RT_NEXT;
          end
        end
      end
      cica_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_st_nxt    = st_r;
          state_nxt     = cica_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cica_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cica_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    st_r        <= st_nxt;
    out_res_r   <= out_res_nxt;
    out_st_r    <= out_st_nxt;
    neg_r       <= neg_nxt;
    root_mode_r <= root_mode_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    cap_r       <= cap_nxt;
    val_r       <= val_nxt;
    cnt_r       <= cnt_nxt;
    over_r      <= over_nxt;
    root_r      <= root_nxt;
    rbit_r      <= rbit_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
  end

  `CICA_ASSERT_IMP(a_err_zero, out_tvalid && (out_tdata[34:32] != cica_pkg::STS_OK), out_tdata[31:0] == 32'd0, "Result is not zero on a failing status.")
  `CICA_ASSERT_NXT(a_take_busy, in_tvalid && in_tready, state_r != cica_pkg::S_IDLE, "Sequencer stayed idle after an input transfer.")
  `CICA_ASSERT_IMP(a_pw_cnt, state_r == cica_pkg::S_PW_CHK, cnt_r != '0, "Power loop checks a product with no factor left.")
  `CICA_ASSERT_IMP(a_div_nz, state_r == cica_pkg::S_DIV, b_r != '0, "Divider runs with a zero divisor.")

endmodule

// ===== test/tb_checked_integer_calculator_alu_top.sv =====
// Self-checking testbench for the checked integer calculator ALU top level.
module tb_checked_integer_calculator_alu_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  longint  acc_first;
  longint  acc_second;
  answer_t pending_answers[$];
  int      error_count = 0;
  int      answers_seen = 0;
  int      burst_left = 0;

  checked_integer_calculator_alu_top uut (.*);

  always #2 clk = ~clk;

  function automatic longint capped_power(longint base, longint exponent, longint cap);
    longint prod;
    prod = 1;
    if (exponent == 0) return 1;
    if (base <= 1) return base;
    for (longint i = 0; i < exponent; i++) begin
      prod = prod * base;
      if (prod > cap) return cap + 1;
    end
    return prod;
  endfunction

  function automatic longint floor_root(longint x, longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = (x < 65535) ? x : 65535;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (capped_power(mid, n, x) <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic answer_t compute_answer(logic [3:0] op, logic signed [30:0] raw);
    longint  lv, a, b, ma, mb, lim, res, p;
    answer_t ans;
    logic [2:0] sts;
    lim = 64'd2147483647;
    lv = raw;
    if (lv > 999999999) lv = 999999999;
    if (lv < -999999999) lv = -999999999;
    a = acc_first;
    b = acc_second;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    res = 0;
    sts = cica_pkg::STS_NONE;
    case (op)
      cica_pkg::OP_LOAD_A: acc_first = lv;
      cica_pkg::OP_LOAD_B: acc_second = lv;
      cica_pkg::OP_SWAP: begin
        acc_first = b;
        acc_second = a;
      end
      cica_pkg::OP_ADD: begin res = a + b; sts = cica_pkg::STS_OK; end
      cica_pkg::OP_SUB: begin res = a - b; sts = cica_pkg::STS_OK; end
      cica_pkg::OP_MUL: begin
        if (a == 0 || b == 0) sts = cica_pkg::STS_OK;
        else if (ma < lim / mb) begin res = a * b; sts = cica_pkg::STS_OK; end
        else sts = cica_pkg::STS_MUL_OVF;
      end
      cica_pkg::OP_DIV: begin
        if (b == 0) sts = cica_pkg::STS_DIVZ;
        else begin res = a / b; sts = cica_pkg::STS_OK; end
      end
      cica_pkg::OP_POW: begin
        if (a == 0 && b < 0) sts = cica_pkg::STS_ZNEG;
        else if (b < 0) begin
          sts = cica_pkg::STS_OK;
          if (a == 1) res = 1;
          else if (a == -1) res = b[0] ? -1 : 1;
        end else begin
          p = capped_power(ma, b, lim);
          if (p > lim) sts = cica_pkg::STS_POW_OVF;
          else begin
            sts = cica_pkg::STS_OK;
            res = (a < 0 && b[0]) ? -p : p;
          end
        end
      end
      cica_pkg::OP_ROOT: begin
        if (!b[0] && a < 0) sts = cica_pkg::STS_EVNEG;
        else if (b == 0) sts = cica_pkg::STS_ZDEG;
        else if (b < 0) begin
          if (a == 0) sts = cica_pkg::STS_DIVZ;
          else begin sts = cica_pkg::STS_OK; res = (ma == 1) ? a : 0; end
        end else begin
          p = (b == 1) ? ma : floor_root(ma, b);
          sts = cica_pkg::STS_OK;
          res = (a < 0) ? -p : p;
        end
      end
      default: ;
    endcase
    if (sts != cica_pkg::STS_OK) res = 0;
    ans.value = res[31:0];
    ans.status = sts;
    return ans;
  endfunction

  task automatic send_item(logic [3:0] op, logic signed [30:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, value, op};
    do @(posedge clk); while (!in_tready);
    pending_answers.push_back(compute_answer(op, value));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending_answers.size() == 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (answers_seen % 200 < 50) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    answer_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[31:0];
      got.status = out_tdata[34:32];
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected transfer: got value %0d status %0d",
                 $time, got.value, got.status);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.value !== want.value) begin
          $display("%0t value mismatch: expected %0d actual %0d", $time, want.value, got.value);
          error_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, got.status);
          error_count++;
        end
      end
    end
  end

  task automatic apply_pair(logic signed [30:0] a, logic signed [30:0] b, logic [3:0] op);
    send_item(cica_pkg::OP_LOAD_A, a);
    send_item(cica_pkg::OP_LOAD_B, b);
    send_item(op, 31'($urandom()));
  endtask

  task automatic test_basic_ops();
    send_item(cica_pkg::OP_ADD, 31'sd0);
    send_item(cica_pkg::OP_LOAD_A, 31'sh3FFFFFFF);
    send_item(cica_pkg::OP_LOAD_B, 31'sh40000000);
    send_item(cica_pkg::OP_SWAP, 31'sd0);
    apply_pair(31'sd999999999, 31'sd999999999, cica_pkg::OP_ADD);
    send_item(cica_pkg::OP_SUB, 31'sd0);
    send_item(4'd9, 31'sh7FFFFFFF);
    send_item(4'd15, 31'sd0);
  endtask

  task automatic test_special_cases();
    apply_pair(31'sd46341, 31'sd46340, cica_pkg::OP_MUL);
    apply_pair(-31'sd999999999, 31'sd3, cica_pkg::OP_MUL);
    apply_pair(-31'sd7, 31'sd0, cica_pkg::OP_DIV);
    apply_pair(-31'sd7, 31'sd2, cica_pkg::OP_DIV);
    apply_pair(31'sd0, -31'sd3, cica_pkg::OP_POW);
    apply_pair(-31'sd1, -31'sd3, cica_pkg::OP_POW);
    apply_pair(31'sd2, 31'sd31, cica_pkg::OP_POW);
    apply_pair(-31'sd2, 31'sd31, cica_pkg::OP_POW);
    apply_pair(-31'sd8, 31'sd0, cica_pkg::OP_ROOT);
    apply_pair(31'sd8, 31'sd0, cica_pkg::OP_ROOT);
    apply_pair(31'sd0, -31'sd2, cica_pkg::OP_ROOT);
    apply_pair(-31'sd1, -31'sd5, cica_pkg::OP_ROOT);
    apply_pair(-31'sd999999999, 31'sd3, cica_pkg::OP_ROOT);
    apply_pair(31'sd999999999, 31'sd999999999, cica_pkg::OP_ROOT);
  endtask

  function automatic logic signed [30:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $signed(31'($urandom_range(0, 6))) - 31'sd3;
      1: return $signed(31'($urandom_range(0, 200))) - 31'sd100;
      2: return $signed(31'($urandom_range(0, 200000))) - 31'sd100000;
      3: return 31'($urandom());
      default: return $signed(31'($urandom_range(0, 2000000000))) - 31'sd1000000000;
    endcase
  endfunction

  task automatic test_random_items();
    logic [3:0] op;
    for (int i = 0; i < 330; i++) begin
      if (i == 160) drain_results();
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(cica_pkg::OP_SWAP, cica_pkg::OP_ROOT));
      if (op == cica_pkg::OP_POW || op == cica_pkg::OP_ROOT) begin
        send_item(cica_pkg::OP_LOAD_A, pick_operand());
        send_item(cica_pkg::OP_LOAD_B, $signed(31'($urandom_range(0, 40))) - 31'sd5);
        send_item(op, 31'sd0);
      end else apply_pair(pick_operand(), pick_operand(), op);
    end
  endtask

  initial begin
    acc_first = 0;
    acc_second = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_special_cases();
    test_random_items();
    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/cica_pkg.sv
rtl/cica_mul_unit.sv
rtl/checked_integer_calculator_alu_top.sv
test/tb_checked_integer_calculator_alu_top.sv
